FILE: src/slcp_pkg.sv
package slcp_pkg;

  localparam int BufferCharsDef    = 8;
  localparam int TicksPerToggleDef = 100;
  localparam int QueueDepth        = 2;

  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharGt    = 8'd62;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] PrintLow  = 8'd33;
  localparam logic [7:0] PrintHigh = 8'd126;

  localparam int TextChars = 17;
  localparam int TextIdxW  = $clog2(TextChars);

  localparam logic [8*TextChars-1:0] RepOn      = {"LED on", CharCr, {10{8'h00}}};
  localparam logic [8*TextChars-1:0] RepOff     = {"LED off", CharCr, {9{8'h00}}};
  localparam logic [8*TextChars-1:0] RepToggle  = {"LED toggled", CharCr, {5{8'h00}}};
  localparam logic [8*TextChars-1:0] RepBlink   = {"LED blinked", CharCr, {5{8'h00}}};
  localparam logic [8*TextChars-1:0] RepUnknown = "unknown command: ";

  typedef enum logic [2:0] {
    JobTick,
    JobEcho,
    JobOn,
    JobOff,
    JobToggle,
    JobBlink,
    JobUnknown
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] echo_byte;
  } job_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       led_level;
    logic       last;
  } out_item_t;

  function automatic logic [8*TextChars-1:0] reply_text(job_kind_e kind);
    logic [8*TextChars-1:0] t;
    case (kind)
      JobOn:     t = RepOn;
      JobOff:    t = RepOff;
      JobToggle: t = RepToggle;
      JobBlink:  t = RepBlink;
      default:   t = RepUnknown;
    endcase
    return t;
  endfunction

  function automatic logic [TextIdxW-1:0] reply_last_idx(job_kind_e kind);
    logic [TextIdxW-1:0] n;
    case (kind)
      JobOn:     n = TextIdxW'(6);
      JobOff:    n = TextIdxW'(7);
      JobToggle: n = TextIdxW'(11);
      JobBlink:  n = TextIdxW'(11);
      default:   n = TextIdxW'(TextChars - 1);
    endcase
    return n;
  endfunction

  function automatic logic [7:0] text_char(logic [8*TextChars-1:0] t,
                                           logic [TextIdxW-1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (idx < TextIdxW'(TextChars)) begin
      c = t[8*(TextChars-1-int'(idx)) +: 8];
    end
    return c;
  endfunction

  function automatic out_item_t make_out(logic v, logic [7:0] b, logic led, logic last);
    out_item_t o;
    o.tx_valid  = v;
    o.tx_byte   = b;
    o.led_level = led;
    o.last      = last;
    return o;
  endfunction

endpackage

FILE: src/slcp_queue.sv
module slcp_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Depth-1:0][Width-1:0] mem_q;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: src/slcp_front.sv
module slcp_front #(
  parameter int BufferChars = slcp_pkg::BufferCharsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  slcp_pkg::in_item_t                   in_data_i,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  output slcp_pkg::job_t                       job_o,
  output logic [BufferChars-1:0][7:0]          word_o,
  output logic [$clog2(BufferChars+1)-1:0]     len_o
);

  import slcp_pkg::*;

  localparam int PosW = $clog2(BufferChars);
  localparam int LenW = $clog2(BufferChars + 1);

  logic [BufferChars-1:0][7:0] buf_q;
  logic [PosW-1:0] wp_q, wp_d;
  logic full_q, full_d;
  logic accept, is_cr, is_print;
  logic is_on, is_off, is_toggle, is_blink;
  logic [LenW-1:0] len;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_cr      = (in_data_i.rx_byte == CharCr);
  assign is_print   = (in_data_i.rx_byte >= PrintLow) && (in_data_i.rx_byte <= PrintHigh);
  assign len        = full_q ? LenW'(BufferChars) : LenW'(wp_q);

  assign is_on     = !full_q && (len == LenW'(2)) && (buf_q[0] == "o") && (buf_q[1] == "n");
  assign is_off    = !full_q && (len == LenW'(3)) && (buf_q[0] == "o") && (buf_q[1] == "f")
                     && (buf_q[2] == "f");
  assign is_toggle = !full_q && (len == LenW'(6)) && (buf_q[0] == "t") && (buf_q[1] == "o")
                     && (buf_q[2] == "g") && (buf_q[3] == "g") && (buf_q[4] == "l")
                     && (buf_q[5] == "e");
  assign is_blink  = !full_q && (len == LenW'(5)) && (buf_q[0] == "b") && (buf_q[1] == "l")
                     && (buf_q[2] == "i") && (buf_q[3] == "n") && (buf_q[4] == "k");

  assign push_o = accept;
  assign word_o = buf_q;
  assign len_o  = len;

  always_comb begin
    job_o.echo_byte = in_data_i.rx_byte;
    if (in_data_i.command) begin
      job_o.kind = JobTick;
    end else if (!is_cr) begin
      job_o.kind = JobEcho;
    end else if (is_on) begin
      job_o.kind = JobOn;
    end else if (is_off) begin
      job_o.kind = JobOff;
    end else if (is_toggle) begin
      job_o.kind = JobToggle;
    end else if (is_blink) begin
      job_o.kind = JobBlink;
    end else begin
      job_o.kind = JobUnknown;
    end
  end

  always_comb begin
    wp_d   = wp_q;
    full_d = full_q;
    if (accept && !in_data_i.command) begin
      if (is_cr) begin
        wp_d   = '0;
        full_d = 1'b0;
      end else if (is_print) begin
        if (wp_q == PosW'(BufferChars - 1)) begin
          wp_d   = '0;
          full_d = 1'b1;
        end else begin
          wp_d = wp_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      full_q <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !in_data_i.command && !is_cr && is_print) begin
      buf_q[wp_q] <= in_data_i.rx_byte;
    end
  end

endmodule

FILE: src/slcp_back.sv
module slcp_back #(
  parameter int BufferChars    = slcp_pkg::BufferCharsDef,
  parameter int TicksPerToggle = slcp_pkg::TicksPerToggleDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_empty_i,
  input  slcp_pkg::job_t                       q_job_i,
  input  logic [BufferChars-1:0][7:0]          q_word_i,
  input  logic [$clog2(BufferChars+1)-1:0]     q_len_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output slcp_pkg::out_item_t                  out_data_o
);

  import slcp_pkg::*;

  localparam int WordIdxW = $clog2(BufferChars);
  localparam int LenW     = $clog2(BufferChars + 1);
  localparam int TickW    = $clog2(TicksPerToggle);

  typedef enum logic [2:0] {
    StIdle,
    StFirst,
    StText,
    StWord,
    StCr,
    StPrompt
  } state_e;

  state_e state_q, state_d;
  job_t job_q, job_d;
  logic [BufferChars-1:0][7:0] word_q, word_d;
  logic [LenW-1:0] len_q, len_d;
  logic [TextIdxW-1:0] txt_idx_q, txt_idx_d;
  logic [WordIdxW-1:0] word_idx_q, word_idx_d;
  logic led_q, led_d, blink_q, blink_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic emit_ok;

  assign emit_ok     = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    word_d      = word_q;
    len_d       = len_q;
    txt_idx_d   = txt_idx_q;
    word_idx_d  = word_idx_q;
    led_d       = led_q;
    blink_d     = blink_q;
    tick_d      = tick_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    q_pop_o     = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_job_i;
          word_d  = q_word_i;
          len_d   = q_len_i;
          state_d = StFirst;
        end
      end
      StFirst: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          case (job_q.kind)
            JobTick: begin
              if (blink_q) begin
                if (tick_q == TickW'(TicksPerToggle - 1)) begin
                  tick_d = '0;
                  led_d  = !led_q;
                end else begin
                  tick_d = tick_q + 1'b1;
                end
              end
              out_d   = make_out(1'b0, 8'h00, led_d, 1'b1);
              state_d = StIdle;
            end
            JobEcho: begin
              out_d   = make_out(1'b1, job_q.echo_byte, led_q, 1'b1);
              state_d = StIdle;
            end
            default: begin
              out_d     = make_out(1'b1, job_q.echo_byte, led_q, 1'b0);
              blink_d   = (job_q.kind == JobBlink);
              txt_idx_d = '0;
              state_d   = StText;
              if (job_q.kind == JobOn) begin
                led_d = 1'b1;
              end else if (job_q.kind == JobOff) begin
                led_d = 1'b0;
              end else if (job_q.kind == JobToggle) begin
                led_d = !led_q;
              end
            end
          endcase
        end
      end
      StText: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_d = make_out(1'b1, text_char(reply_text(job_q.kind), txt_idx_q), led_q, 1'b0);
          if (txt_idx_q == reply_last_idx(job_q.kind)) begin
            txt_idx_d  = '0;
            word_idx_d = '0;
            if (job_q.kind != JobUnknown) begin
              state_d = StPrompt;
            end else if (len_q == '0) begin
              state_d = StCr;
            end else begin
              state_d = StWord;
            end
          end else begin
            txt_idx_d = txt_idx_q + 1'b1;
          end
        end
      end
      StWord: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_d       = make_out(1'b1, word_q[word_idx_q], led_q, 1'b0);
          if (LenW'(word_idx_q) + LenW'(1) == len_q) begin
            state_d = StCr;
          end else begin
            word_idx_d = word_idx_q + 1'b1;
          end
        end
      end
      StCr: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_d       = make_out(1'b1, CharCr, led_q, 1'b0);
          txt_idx_d   = '0;
          state_d     = StPrompt;
        end
      end
      StPrompt: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          if (txt_idx_q == '0) begin
            out_d     = make_out(1'b1, CharGt, led_q, 1'b0);
            txt_idx_d = TextIdxW'(1);
          end else begin
            out_d   = make_out(1'b1, CharSpace, led_q, 1'b1);
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      led_q       <= 1'b0;
      blink_q     <= 1'b0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
      txt_idx_q   <= '0;
      word_idx_q  <= '0;
      job_q       <= '0;
      word_q      <= '0;
      len_q       <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      led_q       <= led_d;
      blink_q     <= blink_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
      txt_idx_q   <= txt_idx_d;
      word_idx_q  <= word_idx_d;
      job_q       <= job_d;
      word_q      <= word_d;
      len_q       <= len_d;
      out_q       <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_tick_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q < TickW'(TicksPerToggle))
    else $error("tick count out of range");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == StIdle) && !q_empty_i)
    else $error("queue pop outside idle");

  a_silent_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.tx_valid |-> out_q.last && (out_q.tx_byte == 8'h00))
    else $error("tick result malformed");

  a_prompt_ends_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPrompt) && (txt_idx_q != '0) && emit_ok |=>
      out_valid_q && out_q.last && (state_q == StIdle))
    else $error("prompt did not close the reply");
`endif

endmodule

FILE: src/serial_led_command_parser_unit.sv
// channel  direction  payload     handshake
// in       input      in_item_t   in_valid_i / in_ready_o
// out      output     out_item_t  out_valid_o / out_ready_i
//
// a tick or a plain byte gives one word, through the queue, the back's job register and its output register, when idle
// a carriage return gives 1 + reply length words (up to 21 + buffer chars),
// one per cycle from the back sequencer while out_ready_i allows, after a one-cycle queue pop
// reset clears control state at once; no clearing pass
// a two-entry job queue lets the front accept while the back is stalled on out_ready_i
module serial_led_command_parser_unit #(
  parameter int BufferChars    = slcp_pkg::BufferCharsDef,
  parameter int TicksPerToggle = slcp_pkg::TicksPerToggleDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slcp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slcp_pkg::out_item_t out_data_o
);

  import slcp_pkg::*;

  localparam int LenW  = $clog2(BufferChars + 1);
  localparam int WordW = 8 * BufferChars;
  localparam int JobW  = $bits(job_t);
  localparam int QW    = JobW + LenW + WordW;

  logic push, pop, q_full, q_empty;
  job_t f_job, b_job;
  logic [BufferChars-1:0][7:0] f_word, b_word;
  logic [LenW-1:0] f_len, b_len;
  logic [QW-1:0] q_in, q_out;

  slcp_front #(
    .BufferChars(BufferChars)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .job_o     (f_job),
    .word_o    (f_word),
    .len_o     (f_len)
  );

  assign q_in = {f_job, f_len, f_word};

  slcp_queue #(
    .Width(QW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .pop_i  (pop),
    .data_o (q_out),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  assign b_job  = job_t'(q_out[QW-1 -: JobW]);
  assign b_len  = q_out[WordW +: LenW];
  assign b_word = q_out[WordW-1:0];

  slcp_back #(
    .BufferChars   (BufferChars),
    .TicksPerToggle(TicksPerToggle)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_job_i    (b_job),
    .q_word_i   (b_word),
    .q_len_i    (b_len),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
